@@ sv/first_fit_block_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// first fit block allocator assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define FFBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define FFBA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFBA_ASSERT(label, prop, msg)
`define FFBA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ sv/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// shared constants, field widths, operation codes and sequencer states
// ----------------------------------------------------------------------------
package ffba_pkg;

	// pool geometry
	localparam int FIRST_POOL_BLOCKS  = 36;
	localparam int SECOND_POOL_BLOCKS = 128;
	localparam int BLOCK_SAMPLES      = 128;
	localparam int TOTAL_BLOCKS       = FIRST_POOL_BLOCKS + SECOND_POOL_BLOCKS;

	// beat field widths
	localparam int FUNC_W     = 2;
	localparam int SAMPLES_W  = 15;
	localparam int START_W    = 7;
	localparam int FREE_CNT_W = 8;
	localparam int OFFSET_W   = 14;
	localparam int USED_W     = 8;

	// internal widths
	localparam int MAP_AW     = $clog2(TOTAL_BLOCKS);
	localparam int IDX_W      = $clog2(TOTAL_BLOCKS + 1);
	localparam int BLK_SHIFT  = $clog2(BLOCK_SAMPLES);
	localparam int NEED_W     = $clog2(((2**SAMPLES_W - 1) >> BLK_SHIFT) + 2);
	localparam int FREE_SUM_W = $clog2(TOTAL_BLOCKS + 2**START_W + 2**FREE_CNT_W + 1);

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC    = 2'd0,
		FN_FREE     = 2'd1,
		FN_FREE_ALL = 2'd2,
		FN_COUNT    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_COUNT,
		ST_DONE
	} state_t;

endpackage

@@ sv/ffba_if.sv @@
// ----------------------------------------------------------------------------
// ffba channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ffba_req_if;
	logic                                valid;
	logic                                ready;
	logic [ffba_pkg::FUNC_W-1:0]         func;
	logic [ffba_pkg::SAMPLES_W-1:0]      sample_count;
	logic                                free_pool;
	logic [ffba_pkg::START_W-1:0]        free_start;
	logic [ffba_pkg::FREE_CNT_W-1:0]     free_blocks;

	modport source (
		output valid, func, sample_count, free_pool, free_start, free_blocks,
		input  ready
	);
	modport sink (
		input  valid, func, sample_count, free_pool, free_start, free_blocks,
		output ready
	);
endinterface

interface ffba_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                ok;
	logic                                alloc_pool;
	logic [ffba_pkg::START_W-1:0]        alloc_start;
	logic [ffba_pkg::OFFSET_W-1:0]       sample_offset;
	logic [ffba_pkg::USED_W-1:0]         used_blocks;

	modport source (
		output valid, ok, alloc_pool, alloc_start, sample_offset, used_blocks,
		input  ready
	);
	modport sink (
		input  valid, ok, alloc_pool, alloc_start, sample_offset, used_blocks,
		output ready
	);
endinterface

@@ sv/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first fit allocator over two block pools kept in one used/free bit memory
// ----------------------------------------------------------------------------
// usage
// - req channel takes one beat per operation: allocate, free range, free all,
//   count used; req.ready is high only while the sequencer is idle
// - rsp channel gives exactly one beat per request; the response sits in an
//   output register, so a new request is taken while it waits, and the next
//   response is held back until rsp.ready frees the register
// - both pools live in one 164 entry bit memory, first pool at the low end;
//   every operation walks it one entry per cycle through a single address
//   counter and increment/compare unit
// - allocate: a scan through the registered read port until a free run is found
//   or the map ends, then a write for each block marked, then a load of the
//   output register; free range: one write per block freed; free all: a
//   clearing pass over the whole map; count: a read of every entry
// - after reset a clearing pass over all 164 entries zeroes the map; req.ready
//   stays low until it ends
// - a stalled receiver only holds the finished response; work on the next
//   request continues until its own result is due
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	ffba_req_if.sink    req,
	ffba_rsp_if.source  rsp
);

	import ffba_pkg::*;

	// sequencer state
	state_t state_q, state_d;
	logic [IDX_W-1:0] addr_q;    // shared walk index
	logic [IDX_W-1:0] end_q;     // walk limit for free and mark
	logic             reply_q;   // clear pass was requested by a beat
	logic             rsp_valid_q;

	// operation working registers
	logic [NEED_W-1:0] need_q;
	logic [NEED_W-1:0] run_q;
	logic [MAP_AW-1:0] first_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              res_ok_q;
	logic              res_alloc_q;

	// response registers
	logic                rsp_ok_q;
	logic                rsp_pool_q;
	logic [START_W-1:0]  rsp_start_q;
	logic [OFFSET_W-1:0] rsp_offset_q;
	logic [USED_W-1:0]   rsp_used_q;

	// memory read pipeline
	logic              rd_vld_s1;
	logic [MAP_AW-1:0] rd_idx_s1;
	logic              rd_bit_s1;

	// memory controls
	logic              mem_we;
	logic              mem_wd;
	logic              issue;

	logic accept;
	logic rsp_load;
	func_t req_func;

	assign req_func = func_t'(req.func);
	assign accept   = req.valid && req.ready;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// ------------------------------------------------------------------
	// free range bounds, clipped to the pool end
	// ------------------------------------------------------------------
	logic [FREE_SUM_W-1:0] free_base, free_len, free_lo_w, free_lim, free_top;
	logic [IDX_W-1:0]      free_lo, free_hi;
	logic                  free_any;

	always_comb begin
		free_base = req.free_pool ? FREE_SUM_W'(FIRST_POOL_BLOCKS) : '0;
		free_len  = req.free_pool ? FREE_SUM_W'(SECOND_POOL_BLOCKS)
		                          : FREE_SUM_W'(FIRST_POOL_BLOCKS);
		free_lo_w = free_base + FREE_SUM_W'(req.free_start);
		free_lim  = free_lo_w + FREE_SUM_W'(req.free_blocks);
		free_top  = free_base + free_len;
		free_any  = (FREE_SUM_W'(req.free_start) < free_len) && (req.free_blocks != '0);
		if (free_any) begin
			free_lo = IDX_W'(free_lo_w);
			free_hi = (free_lim < free_top) ? IDX_W'(free_lim) : IDX_W'(free_top);
		end else begin
			// nothing to free: empty walk
			free_lo = '0;
			free_hi = '0;
		end
	end

	// ------------------------------------------------------------------
	// scan step on the bit that came back from memory
	// ------------------------------------------------------------------
	logic              proc;
	logic              last_idx;
	logic [NEED_W-1:0] base_run, run_nxt;
	logic [MAP_AW-1:0] run_first;
	logic              found;
	logic [IDX_W-1:0]  cnt_nxt;

	always_comb begin
		proc      = rd_vld_s1 && ((state_q == ST_SCAN) || (state_q == ST_COUNT));
		last_idx  = rd_idx_s1 == MAP_AW'(TOTAL_BLOCKS - 1);
		// a run never crosses into the second pool
		base_run  = (rd_idx_s1 == MAP_AW'(FIRST_POOL_BLOCKS)) ? '0 : run_q;
		run_nxt   = rd_bit_s1 ? '0 : base_run + NEED_W'(1);
		run_first = (base_run == '0) ? rd_idx_s1 : first_q;
		found     = !rd_bit_s1 && (run_nxt >= need_q);
		cnt_nxt   = cnt_q + IDX_W'(rd_bit_s1);
	end

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == IDX_W'(TOTAL_BLOCKS - 1)) begin
					state_d = reply_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req_func)
						FN_ALLOC:    state_d = ST_SCAN;
						FN_FREE:     state_d = ST_FREE;
						FN_FREE_ALL: state_d = ST_CLEAR;
						FN_COUNT:    state_d = ST_COUNT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (proc && found) begin
					state_d = ST_MARK;
				end else if (proc && last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_MARK: begin
				if (addr_q == end_q - IDX_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_FREE: begin
				if (addr_q >= end_q) begin
					state_d = ST_DONE;
				end
			end
			ST_COUNT: begin
				if (proc && last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer outputs: memory port controls
	// ------------------------------------------------------------------
	always_comb begin
		mem_we = 1'b0;
		mem_wd = 1'b0;
		issue  = 1'b0;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_MARK: begin
				mem_we = 1'b1;
				mem_wd = 1'b1;
			end
			ST_FREE:  mem_we = addr_q < end_q;
			ST_SCAN:  issue  = addr_q < IDX_W'(TOTAL_BLOCKS);
			ST_COUNT: issue  = addr_q < IDX_W'(TOTAL_BLOCKS);
			default: begin
				mem_we = 1'b0;
				issue  = 1'b0;
			end
		endcase
	end

	ffba_map_ram #(
		.DEPTH (TOTAL_BLOCKS),
		.AW    (MAP_AW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_q[MAP_AW-1:0]),
		.wdata (mem_wd),
		.re    (issue),
		.raddr (addr_q[MAP_AW-1:0]),
		.rdata (rd_bit_s1)
	);

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			reply_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (accept) begin
				reply_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q <= (req_func == FN_FREE) ? free_lo : '0;
					end
				end
				ST_CLEAR, ST_MARK: addr_q <= addr_q + IDX_W'(1);
				ST_FREE: begin
					if (addr_q < end_q) begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				ST_SCAN: begin
					if (proc && found) begin
						// walk now marks the run from its first block
						addr_q <= IDX_W'(run_first);
					end else if (issue) begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				ST_COUNT: begin
					if (issue) begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				default: addr_q <= addr_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// working and response payload registers
	// ------------------------------------------------------------------
	logic [MAP_AW-1:0] local_start;
	logic              first_in_second;

	assign first_in_second = first_q >= MAP_AW'(FIRST_POOL_BLOCKS);
	assign local_start     = first_q - (first_in_second ? MAP_AW'(FIRST_POOL_BLOCKS) : '0);

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[MAP_AW-1:0];

		if (accept) begin
			need_q      <= NEED_W'(req.sample_count >> BLK_SHIFT) + NEED_W'(1);
			run_q       <= '0;
			cnt_q       <= '0;
			res_ok_q    <= 1'b1;
			res_alloc_q <= 1'b0;
			end_q       <= free_hi;
		end

		if (proc && (state_q == ST_SCAN)) begin
			run_q   <= run_nxt;
			first_q <= run_first;
			if (found) begin
				end_q       <= IDX_W'(run_first) + IDX_W'(need_q);
				res_alloc_q <= 1'b1;
			end else if (last_idx) begin
				res_ok_q <= 1'b0;
			end
		end

		if (proc && (state_q == ST_COUNT)) begin
			cnt_q <= cnt_nxt;
		end

		if (rsp_load) begin
			rsp_ok_q   <= res_ok_q;
			rsp_used_q <= USED_W'(cnt_q);
			if (res_alloc_q) begin
				rsp_pool_q   <= first_in_second;
				rsp_start_q  <= START_W'(local_start);
				rsp_offset_q <= OFFSET_W'(32'(local_start) * BLOCK_SAMPLES);
			end else begin
				rsp_pool_q   <= 1'b0;
				rsp_start_q  <= '0;
				rsp_offset_q <= '0;
			end
		end
	end

	assign req.ready         = state_q == ST_IDLE;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = rsp_ok_q;
	assign rsp.alloc_pool    = rsp_pool_q;
	assign rsp.alloc_start   = rsp_start_q;
	assign rsp.sample_offset = rsp_offset_q;
	assign rsp.used_blocks   = rsp_used_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// the current run is always shorter than the request while scanning
	`FFBA_ASSERT(a_run_below_need, (state_q == ST_SCAN) |-> (run_q < need_q), "run reached need in scan")
	// marking stays inside the run that was found
	`FFBA_ASSERT(a_mark_in_run, (state_q == ST_MARK) |-> (addr_q < end_q), "mark walked past run")
	// a failed allocation reports no position and no count
	`FFBA_ASSERT(a_fail_zero, (rsp.valid && !rsp.ok) |-> (rsp.alloc_start == '0 && rsp.used_blocks == '0 && !rsp.alloc_pool), "failed allocate reports data")
	// no request is taken during the clearing pass
	`FFBA_ASSERT_ALWAYS(a_no_accept_clear, (state_q == ST_CLEAR) |-> !req.ready, "ready during clear")

endmodule

@@ sv/ffba_map_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_map_ram
// one write port, one registered read port block map memory
// ----------------------------------------------------------------------------
module ffba_map_ram #(
	parameter int DEPTH = 164,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
